// ===== design/sgef_pkg.sv =====
// Shared constants and types of the Sobel gradient energy focus block.
`timescale 1ns / 1ps
package sgef_pkg;

  // Field widths of the channels.
  localparam int PIXEL_W = 8;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 4;
  localparam int SUM_W   = 43;
  localparam int COUNT_W = 23;
  localparam int MEAN_W  = 29;

  // Default geometry and precision.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_FRAC_BITS  = 8;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd1280;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd1024;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  // Gx^2 or Gy^2 of one pixel fits 20 bits (1020^2).
  localparam int SQ_W   = 20;
  // Signed Sobel response, +-1020.
  localparam int GRAD_W = 11;

  // One column of the 3x3 window.
  typedef struct packed {
    logic [PIXEL_W-1:0] up;
    logic [PIXEL_W-1:0] mid;
    logic [PIXEL_W-1:0] dn;
  } col_t;

endpackage

// ===== design/sgef_if.sv =====
// Valid/ready channel interfaces: pixel in, frame result out, register writes.
`timescale 1ns / 1ps
interface sgef_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [sgef_pkg::PIXEL_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sgef_result_if;
  logic                         valid;
  logic                         ready;
  logic [sgef_pkg::SUM_W-1:0]   gradient_sum;
  logic [sgef_pkg::COUNT_W-1:0] pixel_count;
  logic [sgef_pkg::MEAN_W-1:0]  mean_energy;
  modport source (output valid, output gradient_sum, output pixel_count,
                  output mean_energy, input ready);
  modport sink   (input valid, input gradient_sum, input pixel_count,
                  input mean_energy, output ready);
endinterface

interface sgef_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sgef_pkg::CFG_IDX_W-1:0] index;
  logic [sgef_pkg::CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/sgef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sgef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wen_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wen_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/sgef_div.sv =====
// Restoring divider, one quotient bit per cycle, keeps the low quotient bits.
`timescale 1ns / 1ps
module sgef_div #(
  parameter int DVD_W  = 53,
  parameter int DVS_W  = 24,
  parameter int QUOT_W = 29
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    trial;
  logic              take;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign take  = trial >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      rem_d = take ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
      quo_d = {quo_q[QUOT_W-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/sobel_gradient_energy_focus.sv =====
// Top level: Tenengrad focus measure (3x3 Sobel energy) over one grey frame.
//
//  channel  | dir | payload                                        | accepted when
//  ---------+-----+------------------------------------------------+--------------------
//  pix_i    | in  | pixel[7:0]                                     | valid && ready
//  res_o    | out | gradient_sum[42:0] pixel_count[22:0] mean[28:0]| valid && ready
//  cfg_i    | in  | index[3:0] data[11:0] (0 width, 1 height)      | valid && ready (=1)
//
// Flow: one pixel word per clock within a row, a bubble at each row end.
// At frame end the last row is swept again from the line RAM, and then the
// mean is formed by a serial divider, one quotient bit per clock. Reset:
// registers return to 1280 x 1024, counters and the sum to zero; the line
// RAM is not cleared. A waiting result does not stop the next frame; only a
// second finished frame waits for the result to be taken.
`timescale 1ns / 1ps
module sobel_gradient_energy_focus #(
  parameter int MAX_WIDTH  = sgef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgef_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = sgef_pkg::DEF_FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sgef_pixel_if.sink    pix_i,
  sgef_cfg_if.sink      cfg_i,
  sgef_result_if.source res_o
);
  import sgef_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int AREA_W = WW + HW;
  localparam int ACC_W  = AREA_W + SQ_W + 1;
  localparam int DVD_W  = ACC_W + FRAC_BITS;

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DIV   = 4'b1000
  } state_e;

  // Control riding with a column read into the window stage.
  typedef struct packed {
    logic             flush;   // final-row sweep, no RAM write
    logic             calc;    // row above exists, produce gradients
    logic             row1;    // top border: row above mirrors to current
    logic             first;
    logic             second;
    logic             last;
    logic [COL_W-1:0] col;
  } s1_ctl_t;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] fw_q, fh_q;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic [AREA_W-1:0] area_q;
  logic             cfg_wr, cfg_hit;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr  = cfg_i.valid && cfg_i.ready;
  assign cfg_hit = cfg_wr && (cfg_i.index == REG_FRAME_WIDTH ||
                              cfg_i.index == REG_FRAME_HEIGHT);

  // Sizes saturate to [3, MAX]
  always_comb begin
    if (fw_q < CFG_W'(3))                  w_eff = WW'(3);
    else if (32'(fw_q) > MAX_WIDTH)        w_eff = WW'(MAX_WIDTH);
    else                                   w_eff = WW'(fw_q);
    if (fh_q < CFG_W'(3))                  h_eff = HW'(3);
    else if (32'(fh_q) > MAX_HEIGHT)       h_eff = HW'(MAX_HEIGHT);
    else                                   h_eff = HW'(fh_q);
  end

  assign w_last = COL_W'(w_eff - 1'b1);
  assign h_last = ROW_W'(h_eff - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= RST_FRAME_WIDTH;
      fh_q <= RST_FRAME_HEIGHT;
    end else if (cfg_wr) begin
      unique case (cfg_i.index)
        REG_FRAME_WIDTH:  fw_q <= cfg_i.data;
        REG_FRAME_HEIGHT: fh_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // frame area, static between writes
  always_ff @(posedge clk_i) begin
    area_q <= AREA_W'(w_eff) * AREA_W'(h_eff);
  end

  // ---------------- sequencer ----------------
  state_e           state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             s1_valid_q;
  s1_ctl_t          s1_ctl_q, s1_ctl_d;
  logic [PIXEL_W-1:0] s1_pix_q;
  logic             tail_q;
  logic             s2_valid_q, s3_valid_q;
  logic             res_valid_q;
  logic             slot_busy;       // S1 slot kept free next cycle for a row tail (if any)
  logic             pix_take, flush_issue, issue;
  logic             pipe_empty, div_start, div_done;

  assign slot_busy   = s1_valid_q && s1_ctl_q.last;
  assign pix_i.ready = (state_q == ST_RUN) && !slot_busy;
  assign pix_take    = pix_i.valid && pix_i.ready;
  assign flush_issue = (state_q == ST_FLUSH) && !slot_busy;
  assign issue       = pix_take || flush_issue;
  assign pipe_empty  = !s1_valid_q && !tail_q && !s2_valid_q && !s3_valid_q;
  assign div_start   = (state_q == ST_DRAIN) && pipe_empty && !res_valid_q;

  always_comb begin
    s1_ctl_d.flush  = (state_q == ST_FLUSH);
    s1_ctl_d.calc   = (state_q == ST_FLUSH) || (row_q != '0);
    s1_ctl_d.row1   = (state_q != ST_FLUSH) && (row_q == ROW_W'(1));
    s1_ctl_d.first  = (col_q == '0);
    s1_ctl_d.second = (col_q == COL_W'(1));
    s1_ctl_d.last   = (col_q == w_last);
    s1_ctl_d.col    = col_q;
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    unique case (state_q)
      ST_RUN: begin
        if (pix_take) begin
          if (col_q == w_last) begin
            col_d = '0;
            if (row_q == h_last) begin
              row_d   = '0;
              state_d = ST_FLUSH;
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (flush_issue) begin
          if (col_q == w_last) begin
            col_d   = '0;
            state_d = ST_DRAIN;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (div_start) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
    // register writes abandon the frame; user must write only while idle (unchecked)
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      tail_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= issue;
      tail_q     <= s1_valid_q && s1_ctl_q.last && s1_ctl_q.calc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ctl_q <= s1_ctl_d;
      s1_pix_q <= pix_i.pixel;
    end
  end

  // ---------------- line RAM: word = {row r-2, row r-1} ----------------
  logic [2*PIXEL_W-1:0] ram_rdata;
  logic [PIXEL_W-1:0]   two_up, one_up;
  logic                 ram_wen;

  assign ram_wen = s1_valid_q && !s1_ctl_q.flush;

  sgef_ram #(
    .WIDTH (2 * PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .wen_i   (ram_wen),
    .waddr_i (s1_ctl_q.col),
    .wdata_i ({one_up, s1_pix_q}),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign two_up = ram_rdata[2*PIXEL_W-1:PIXEL_W];
  assign one_up = ram_rdata[PIXEL_W-1:0];

  // ---------------- window and Sobel ----------------
  col_t new_col, win1_q, win2_q;
  col_t lft, ctr, rgt;
  logic op_valid;
  logic signed [GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;

  always_comb begin
    if (s1_ctl_q.flush) begin
      // bottom border: row below mirrors to the row above
      new_col.up = two_up;
      new_col.dn = two_up;
    end else begin
      new_col.up = s1_ctl_q.row1 ? s1_pix_q : two_up;
      new_col.dn = s1_pix_q;
    end
    new_col.mid = one_up;
  end

  always_comb begin
    if (tail_q) begin
      // right border: column past the end mirrors to the one before
      lft = win2_q;
      ctr = win1_q;
      rgt = win2_q;
    end else begin
      lft = s1_ctl_q.second ? new_col : win2_q;
      ctr = win1_q;
      rgt = new_col;
    end
  end

  assign op_valid = (s1_valid_q && s1_ctl_q.calc && !s1_ctl_q.first) || tail_q;

  function automatic logic signed [GRAD_W-1:0] ext(input logic [PIXEL_W-1:0] v);
    ext = signed'(GRAD_W'(v));
  endfunction

  always_comb begin
    gx_d = (ext(rgt.up) - ext(lft.up)) + ((ext(rgt.mid) - ext(lft.mid)) <<< 1)
         + (ext(rgt.dn) - ext(lft.dn));
    gy_d = (ext(lft.dn) + (ext(ctr.dn) <<< 1) + ext(rgt.dn))
         - (ext(lft.up) + (ext(ctr.up) <<< 1) + ext(rgt.up));
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win2_q <= win1_q;
      win1_q <= new_col;
    end
    gx_q <= gx_d;
    gy_q <= gy_d;
  end

  // ---------------- squares and accumulator ----------------
  logic signed [2*GRAD_W-1:0] px, py;
  logic [SQ_W-1:0]  sqx_q, sqy_q;
  logic [ACC_W-1:0] acc_q, sum_q;

  assign px = gx_q * gx_q;
  assign py = gy_q * gy_q;

  always_ff @(posedge clk_i) begin
    sqx_q <= px[SQ_W-1:0];
    sqy_q <= py[SQ_W-1:0];
    if (div_start) sum_q <= acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      s2_valid_q <= op_valid;
      s3_valid_q <= s2_valid_q;
      if (cfg_hit || div_start) begin
        acc_q <= '0;
      end else if (s3_valid_q) begin
        acc_q <= acc_q + ACC_W'(sqx_q) + ACC_W'(sqy_q);
      end
    end
  end

  // ---------------- mean and result word ----------------
  logic [MEAN_W-1:0] quotient;

  sgef_div #(
    .DVD_W  (DVD_W),
    .DVS_W  (AREA_W),
    .QUOT_W (MEAN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DVD_W'(acc_q) << FRAC_BITS),
    .divisor_i  (area_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  logic [SUM_W-1:0]   res_sum_q;
  logic [COUNT_W-1:0] res_cnt_q;
  logic [MEAN_W-1:0]  res_mean_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (div_done) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      res_sum_q  <= SUM_W'(sum_q);
      res_cnt_q  <= COUNT_W'(area_q);
      res_mean_q <= quotient;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.gradient_sum = res_sum_q;
  assign res_o.pixel_count  = res_cnt_q;
  assign res_o.mean_energy  = res_mean_q;

  // ---------------- assertions ----------------
  a_tail_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q |-> !s1_valid_q)
    else $error("row tail collides with a column in the window stage");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> !res_valid_q)
    else $error("mean finished while the previous result still waits");

  a_sum_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (!s2_valid_q && !s3_valid_q && !op_valid))
    else $error("gradient work still in flight during division");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the division phase");

endmodule
